[hdl/haptic_motor_pulse_scheduler_macros.svh]
// Assertion macros used by the scheduler control module.
`ifndef HAPTIC_MOTOR_PULSE_SCHEDULER_MACROS_SVH
`define HAPTIC_MOTOR_PULSE_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define HMPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define HMPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HMPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hdl/hmps_pkg.sv]
package hmps_pkg;

    localparam int OP_W     = 3;
    localparam int DUR_W    = 15;
    localparam int STR_W    = 7;
    localparam int SPIN_W   = 3;
    localparam int ACC_W    = 13;
    localparam int SLIP_W   = 3;
    localparam int PER_W    = 3;
    localparam int KIND_W   = 2;
    localparam int MC_W     = 2;
    localparam int FRAME_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int SQ_W     = 2 * STR_W;
    localparam int CUBE_W   = 3 * STR_W;
    localparam int CUBE_SHIFT = 9;
    localparam int CUBE_SH_W  = CUBE_W - CUBE_SHIFT;

    // frame remainder unit: bits folded per cycle and cycles per frame
    localparam int MOD_BITS   = 8;
    localparam int MOD_CYCLES = FRAME_W / MOD_BITS;

    localparam int QUEUE_DEPTH_DEF = 3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_QUEUE    = 3'd1,
        OP_DECAY    = 3'd2,
        OP_SLIP     = 3'd3,
        OP_VIBRATE  = 3'd4,
        OP_SUBMERGE = 3'd5,
        OP_CANCEL   = 3'd6
    } t_op;

    typedef enum logic [MC_W-1:0] {
        MC_NONE  = 2'd0,
        MC_STOP  = 2'd1,
        MC_START = 2'd2
    } t_motor;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEADY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GATED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STRONG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPINUP_TICKS     = 1'd1;

    localparam logic [STR_W-1:0]  STRONG_THRESHOLD_RST = 7'd70;
    localparam logic [SPIN_W-1:0] SPINUP_TICKS_RST     = 3'd4;

    localparam logic [ACC_W-1:0]  DENSITY_UNIT  = 13'h100;
    localparam logic [ACC_W-1:0]  DENSITY_BIAS  = 13'd4;
    localparam logic [SLIP_W-1:0] SLIP_START    = 3'd7;
    localparam logic [SLIP_W-1:0] SLIP_FLOOR    = 3'd4;
    localparam logic [SLIP_W-1:0] SLIP_STEADY   = 3'd5;
    localparam logic [SLIP_W-1:0] SLIP_PERIODIC = 3'd2;
    localparam logic [PER_W-1:0]  SLIP_VIBRATE  = 3'd7;
    localparam logic [PER_W-1:0]  SUBMERGED_PERIOD = 3'd4;
    localparam logic [PER_W-1:0]  VIBRATE_BASE  = 3'd5;
    localparam logic [STR_W-1:0]  VIBRATE_MAX_LEVEL = 7'd4;
    localparam logic [PER_W-1:0]  PERIOD_RST    = 3'd1;

    typedef struct packed {
        logic latch;        // capture the accepted item
        logic exec;         // apply a non-tick command and write its result
        logic load;         // tick: load queue head, advance queue
        logic mod_step;     // tick: fold next frame bits into remainder
        logic tick_commit;  // tick: update pulse state and write result
    } t_dp_cmd;

    typedef struct packed {
        logic op_tick;
    } t_dp_stat;

endpackage

[hdl/haptic_motor_pulse_scheduler.sv]
// Vibration motor scheduler: one motor decision for every item.
// Input channel: i_in_valid / o_in_stall with opcode, duration, strength,
// decay step, reset hold, demo flag and frame number. Opcode tick advances
// the pulse queue and decides start or stop; the other opcodes queue a
// pulse, set its decay, raise slip, vibrate or submerged alerts, or cancel.
// Output channel: o_out_valid / i_out_stall with motor command and idle flag,
// exactly one result per input item, in order.
// Config port: i_cfg_we writes register i_cfg_index (0 strong threshold,
// 1 spin-up ticks) from i_cfg_data; write only while the block is idle.
// Sequence: a non-tick item is applied in the exec state, which registers its
// result; a tick loads the queue head in the exec state, then passes through
// the remainder state, where the frame remainder unit folds 8 frame bits a
// cycle while the decay and cube multiplies settle, and then the finish state,
// which registers the result.
// One item is in flight at a time; the next is accepted once the result is
// registered, even if that result is still waiting.
// A stalled result holds; a finished item waits until the output register
// frees. Reset restores default registers and period, empties the queue and
// clears other pulse state; the block is ready on the first cycle after reset.
module haptic_motor_pulse_scheduler import hmps_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [DUR_W-1:0]      i_duration,
    input  logic [STR_W-1:0]      i_strength,
    input  logic [STR_W-1:0]      i_decay_step,
    input  logic                  i_reset_hold,
    input  logic                  i_demo_playing,
    input  logic [FRAME_W-1:0]    i_frame_number,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [MC_W-1:0]       o_motor_command,
    output logic                  o_idle
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    hmps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    hmps_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_duration      (i_duration),
        .i_strength      (i_strength),
        .i_decay_step    (i_decay_step),
        .i_reset_hold    (i_reset_hold),
        .i_demo_playing  (i_demo_playing),
        .i_frame_number  (i_frame_number),
        .o_motor_command (o_motor_command),
        .o_idle          (o_idle)
    );

endmodule

[hdl/hmps_ctrl.sv]
`include "haptic_motor_pulse_scheduler_macros.svh"

module hmps_ctrl import hmps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam int CNT_W = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_CYCLES - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_MOD    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             write_result;

    assign out_free     = !r_out_valid || !i_out_stall;
    assign write_result = o_cmd.exec || o_cmd.tick_commit;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.op_tick) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MOD;
                end else if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.tick_commit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (write_result) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // a result must never land on one still waiting to be taken
    `HMPS_ASSERT(a_no_overwrite, i_clk, i_rst_n, write_result |-> !(r_out_valid && i_out_stall), "result overwrites pending item")
    `HMPS_ASSERT(a_accept_to_exec, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC), "accepted item not dispatched")
    `HMPS_ASSERT(a_finish_after_mod, i_clk, i_rst_n, (r_state == S_FINISH) |-> ($past(r_state) == S_MOD || $past(r_state) == S_FINISH), "tick finished without remainder pass")
    `HMPS_ASSERT(a_one_cmd, i_clk, i_rst_n, $onehot0({o_cmd.latch, o_cmd.exec, o_cmd.load, o_cmd.mod_step, o_cmd.tick_commit}), "conflicting datapath commands")

endmodule

[hdl/hmps_dp.sv]
module hmps_dp import hmps_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [DUR_W-1:0]      i_duration,
    input  logic [STR_W-1:0]      i_strength,
    input  logic [STR_W-1:0]      i_decay_step,
    input  logic                  i_reset_hold,
    input  logic                  i_demo_playing,
    input  logic [FRAME_W-1:0]    i_frame_number,
    output logic [MC_W-1:0]       o_motor_command,
    output logic                  o_idle
);

    localparam int LAST = QUEUE_DEPTH - 1;

    // configuration
    logic [STR_W-1:0]  r_strong_thr;
    logic [SPIN_W-1:0] r_spinup_ticks;

    // captured item
    logic [OP_W-1:0]  r_op;
    logic [DUR_W-1:0] r_dur;
    logic [STR_W-1:0] r_str;
    logic [STR_W-1:0] r_dec;
    logic             r_hold;
    logic             r_demo;

    // pulse state
    logic [KIND_W-1:0] r_q_kind [QUEUE_DEPTH];
    logic [STR_W-1:0]  r_q_str  [QUEUE_DEPTH];
    logic [DUR_W-1:0]  r_q_dur  [QUEUE_DEPTH];
    logic [STR_W-1:0]  r_q_dec  [QUEUE_DEPTH];
    logic [KIND_W-1:0] n_q_kind [QUEUE_DEPTH];
    logic [STR_W-1:0]  n_q_str  [QUEUE_DEPTH];
    logic [DUR_W-1:0]  n_q_dur  [QUEUE_DEPTH];
    logic [STR_W-1:0]  n_q_dec  [QUEUE_DEPTH];
    logic [KIND_W-1:0] r_act_kind, n_act_kind;
    logic [STR_W-1:0]  r_act_str, n_act_str;
    logic [STR_W-1:0]  r_act_dec, n_act_dec;
    logic [DUR_W-1:0]  r_remain, n_remain;
    logic [SPIN_W-1:0] r_spin, n_spin;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [SLIP_W-1:0] r_slip, n_slip;
    logic [PER_W-1:0]  r_period, n_period;

    // tick datapath: decayed strength, square, cube, frame remainder
    logic [STR_W-1:0]     r_str_dec;
    logic [SQ_W-1:0]      r_sq;
    logic [CUBE_SH_W-1:0] r_cube_sh;
    logic [CUBE_W-1:0]    cube;
    logic [FRAME_W-1:0]   r_mod_frame, n_mod_frame;
    logic [PER_W-1:0]     r_mod_rem, n_mod_rem;
    logic [PER_W-1:0]     per;

    // result
    logic [MC_W-1:0] r_motor, n_motor;
    logic            r_idle, n_idle;

    assign o_stat.op_tick  = (r_op == OP_TICK);
    assign o_motor_command = r_motor;
    assign o_idle          = r_idle;
    assign per             = (r_period == '0) ? PERIOD_RST : r_period;
    assign cube            = CUBE_W'(r_sq) * CUBE_W'(r_str_dec);

    function automatic logic [SLIP_W-1:0] arm_slip(input logic [SLIP_W-1:0] s);
        logic [SLIP_W-1:0] v;
        v = (s == '0) ? SLIP_START : s;
        if (v < SLIP_FLOOR) v = SLIP_FLOOR;
        return v;
    endfunction

    // fold MOD_BITS frame bits, MSB first, into the remainder by per
    always_comb begin
        logic [PER_W:0]     t;
        logic [PER_W-1:0]   rem;
        logic [FRAME_W-1:0] fr;
        rem = r_mod_rem;
        fr  = r_mod_frame;
        for (int k = 0; k < MOD_BITS; k++) begin
            t  = {rem, fr[FRAME_W-1]};
            fr = fr << 1;
            if (t >= {1'b0, per}) t = t - {1'b0, per};
            rem = t[PER_W-1:0];
        end
        n_mod_rem   = rem;
        n_mod_frame = fr;
    end

    always_comb begin
        logic [DUR_W:0] busy;
        logic           q_empty;
        n_q_kind   = r_q_kind;
        n_q_str    = r_q_str;
        n_q_dur    = r_q_dur;
        n_q_dec    = r_q_dec;
        n_act_kind = r_act_kind;
        n_act_str  = r_act_str;
        n_act_dec  = r_act_dec;
        n_remain   = r_remain;
        n_spin     = r_spin;
        n_acc      = r_acc;
        n_slip     = r_slip;
        n_period   = r_period;
        n_motor    = MC_NONE;

        if (i_cmd.exec) begin
            case (r_op)
                OP_QUEUE: begin
                    if (!r_demo) begin
                        n_q_kind[LAST] = (r_str > r_strong_thr) ? KIND_STEADY : KIND_GATED;
                        n_q_str[LAST]  = r_str;
                        n_q_dur[LAST]  = r_dur;
                        n_q_dec[LAST]  = '0;
                    end
                end
                OP_DECAY: n_q_dec[LAST] = r_dec;
                OP_SLIP: begin
                    if (!r_demo) begin
                        n_slip   = arm_slip(r_slip);
                        n_period = SLIP_VIBRATE;
                    end
                end
                OP_VIBRATE: begin
                    if (!r_demo) begin
                        n_slip = arm_slip(r_slip);
                        if (r_str <= VIBRATE_MAX_LEVEL) begin
                            n_period = VIBRATE_BASE - r_str[PER_W-1:0];
                        end
                    end
                end
                OP_SUBMERGE: begin
                    if (!r_demo) begin
                        n_slip   = SLIP_FLOOR;
                        n_period = SUBMERGED_PERIOD;
                    end
                end
                OP_CANCEL: begin
                    for (int i = 0; i < QUEUE_DEPTH; i++) n_q_kind[i] = KIND_NONE;
                    n_remain = '0;
                    n_slip   = '0;
                    n_motor  = MC_STOP;
                end
                default: ;
            endcase
        end

        if (i_cmd.load) begin
            if (r_q_kind[0] != KIND_NONE) begin
                n_acc      = '0;
                n_spin     = r_spinup_ticks;
                n_act_kind = r_q_kind[0];
                n_remain   = r_q_dur[0];
                n_act_str  = r_q_str[0];
                n_act_dec  = r_q_dec[0];
            end
            for (int i = 0; i < LAST; i++) begin
                n_q_kind[i] = r_q_kind[i+1];
                n_q_str[i]  = r_q_str[i+1];
                n_q_dur[i]  = r_q_dur[i+1];
                n_q_dec[i]  = r_q_dec[i+1];
            end
            n_q_kind[LAST] = KIND_NONE;
        end

        if (i_cmd.tick_commit) begin
            if (r_hold) begin
                n_motor = MC_STOP;
            end else begin
                if (r_spin != '0) begin
                    n_spin  = r_spin - 1'b1;
                    n_motor = MC_START;
                end else if (r_remain != '0) begin
                    n_remain  = r_remain - 1'b1;
                    n_act_str = r_str_dec;
                    if (r_act_kind == KIND_STEADY) begin
                        n_motor = MC_START;
                    end else if (r_acc >= DENSITY_UNIT) begin
                        n_acc   = r_acc - DENSITY_UNIT;
                        n_motor = MC_START;
                    end else begin
                        // 13-bit wrap is the accumulator mask
                        n_acc   = r_acc + ACC_W'(r_cube_sh) + DENSITY_BIAS;
                        n_motor = MC_STOP;
                    end
                end else if (r_slip >= SLIP_STEADY) begin
                    n_motor = MC_START;
                end else if (r_slip >= SLIP_PERIODIC && r_mod_rem == '0) begin
                    n_motor = MC_START;
                end else begin
                    n_motor = MC_STOP;
                end
                if (r_slip != '0) n_slip = r_slip - 1'b1;
            end
        end

        busy    = {1'b0, n_remain} + (DUR_W+1)'(n_spin);
        q_empty = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (n_q_kind[i] != KIND_NONE) q_empty = 1'b0;
        end
        n_idle = q_empty && (busy < (DUR_W+1)'(r_spinup_ticks));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strong_thr   <= STRONG_THRESHOLD_RST;
            r_spinup_ticks <= SPINUP_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STRONG_THRESHOLD: r_strong_thr   <= i_cfg_data[STR_W-1:0];
                REG_SPINUP_TICKS:     r_spinup_ticks <= i_cfg_data[SPIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_q_kind[i] <= KIND_NONE;
                r_q_str[i]  <= '0;
                r_q_dur[i]  <= '0;
                r_q_dec[i]  <= '0;
            end
            r_act_kind <= KIND_NONE;
            r_act_str  <= '0;
            r_act_dec  <= '0;
            r_remain   <= '0;
            r_spin     <= '0;
            r_acc      <= '0;
            r_slip     <= '0;
            r_period   <= PERIOD_RST;
        end else begin
            r_q_kind   <= n_q_kind;
            r_q_str    <= n_q_str;
            r_q_dur    <= n_q_dur;
            r_q_dec    <= n_q_dec;
            r_act_kind <= n_act_kind;
            r_act_str  <= n_act_str;
            r_act_dec  <= n_act_dec;
            r_remain   <= n_remain;
            r_spin     <= n_spin;
            r_acc      <= n_acc;
            r_slip     <= n_slip;
            r_period   <= n_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op        <= i_opcode;
            r_dur       <= i_duration;
            r_str       <= i_strength;
            r_dec       <= i_decay_step;
            r_hold      <= i_reset_hold;
            r_demo      <= i_demo_playing;
            r_mod_frame <= i_frame_number;
            r_mod_rem   <= '0;
        end else if (i_cmd.mod_step) begin
            r_mod_frame <= n_mod_frame;
            r_mod_rem   <= n_mod_rem;
        end
        if (i_cmd.exec || i_cmd.tick_commit) begin
            r_motor <= n_motor;
            r_idle  <= n_idle;
        end
        // strength pipeline settles during the remainder pass
        r_str_dec <= (r_act_str > r_act_dec) ? (r_act_str - r_act_dec) : '0;
        r_sq      <= SQ_W'(r_str_dec) * SQ_W'(r_str_dec);
        r_cube_sh <= cube[CUBE_W-1:CUBE_SHIFT];
    end

endmodule
